// ===== rtl/bldcos_pkg.sv =====
`timescale 1ns / 1ps
// Package for the BLDC open-loop start sequencer: phase codes, register
// indexes, reset values, shared structs and the commutation lookup functions.
// No dependencies.
package bldcos_pkg;

    localparam int STEPS_PER_CYCLE = 6;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_TABLE      = 3'd0;
    localparam logic [2:0] CFG_ALIGN_TCK  = 3'd1;
    localparam logic [2:0] CFG_ALIGN_DUTY = 3'd2;
    localparam logic [2:0] CFG_RAMP_DUTY  = 3'd3;
    localparam logic [2:0] CFG_RAMP_PER   = 3'd4;
    localparam logic [2:0] CFG_DUTY_STEP  = 3'd5;
    localparam logic [2:0] CFG_DUTY_MAX   = 3'd6;
    localparam logic [2:0] CFG_RUN_MODE   = 3'd7;

    localparam logic [17:0] RST_TABLE      = 18'd156877;
    localparam logic [7:0]  RST_ALIGN_TCK  = 8'd25;
    localparam logic [9:0]  RST_ALIGN_DUTY = 10'd560;
    localparam logic [9:0]  RST_RAMP_DUTY  = 10'd480;
    localparam logic [7:0]  RST_RAMP_PER   = 8'd20;
    localparam logic [7:0]  RST_DUTY_STEP  = 8'd30;
    localparam logic [9:0]  RST_DUTY_MAX   = 10'd1000;
    localparam logic [1:0]  RST_RUN_MODE   = 2'd1;

    localparam logic [2:0] ALIGN_STATE = 3'd4;

    localparam logic [1:0] MODE_FWD = 2'd1;
    localparam logic [1:0] MODE_REV = 2'd2;

    // external phase codes
    localparam logic [1:0] PHC_IDLE   = 2'd0;
    localparam logic [1:0] PHC_ALIGN  = 2'd1;
    localparam logic [1:0] PHC_RAMP   = 2'd2;
    localparam logic [1:0] PHC_HANDED = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_ALIGN  = 4'b0010,
        PH_RAMP   = 4'b0100,
        PH_HANDED = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [17:0] table_bits;
        logic [7:0]  align_ticks;
        logic [9:0]  align_duty;
        logic [9:0]  ramp_duty;
        logic [7:0]  ramp_period;
        logic [7:0]  duty_step;
        logic [9:0]  duty_max;
        logic [1:0]  bridge_mode;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  period;
        logic [7:0]  countdown;
        logic [2:0]  step_idx;
        logic [9:0]  duty;
        logic [2:0]  comm_state;
    } t_state;

    typedef struct packed {
        logic [1:0] phase;
        logic       drive_valid;
        logic [2:0] drive_pair;
        logic [2:0] comm_state;
        logic [9:0] duty;
        logic       handover;
        logic [9:0] handover_value;
    } t_result;

    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        unique case (ph)
            PH_IDLE:   code = PHC_IDLE;
            PH_ALIGN:  code = PHC_ALIGN;
            PH_RAMP:   code = PHC_RAMP;
            PH_HANDED: code = PHC_HANDED;
            default:   code = PHC_IDLE;
        endcase
        return code;
    endfunction

    function automatic logic [2:0] table_entry(input logic [17:0] tbl, input logic [2:0] idx);
        logic [2:0] e;
        unique case (idx)
            3'd0:    e = tbl[2:0];
            3'd1:    e = tbl[5:3];
            3'd2:    e = tbl[8:6];
            3'd3:    e = tbl[11:9];
            3'd4:    e = tbl[14:12];
            3'd5:    e = tbl[17:15];
            default: e = 3'd0;
        endcase
        return e;
    endfunction

    function automatic logic [2:0] pair_fwd(input logic [2:0] st);
        logic [2:0] p;
        unique case (st)
            3'd1:    p = 3'd2;
            3'd2:    p = 3'd4;
            3'd3:    p = 3'd1;
            3'd5:    p = 3'd5;
            3'd6:    p = 3'd3;
            default: p = 3'd0;
        endcase
        return p;
    endfunction

    function automatic logic [2:0] pair_rev(input logic [2:0] st);
        logic [2:0] p;
        unique case (st)
            3'd1:    p = 3'd3;
            3'd2:    p = 3'd5;
            3'd4:    p = 3'd1;
            3'd5:    p = 3'd4;
            3'd6:    p = 3'd2;
            default: p = 3'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/bldc_open_loop_start_sequencer.sv =====
`timescale 1ns / 1ps
// BLDC open-loop start sequencer. Each accepted item is one control tick;
// the block takes one tick per clock cycle unless stalled, through the input
// register, then the tick update into the result register. Acceptance
// pauses only while the result register is full and stalled. Registers must
// be written through a plain write port only while no tick is in flight;
// the block does not enforce this. The sequence state lives in this file.
// Depends on bldcos_pkg, bldcos_cfg and bldcos_step.
module bldc_open_loop_start_sequencer import bldcos_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [17:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_start_request,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_phase,
    output logic        o_drive_valid,
    output logic [2:0]  o_drive_pair,
    output logic [2:0]  o_comm_state,
    output logic [9:0]  o_duty,
    output logic        o_handover,
    output logic [9:0]  o_handover_value
);

    t_cfg    w_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_in_valid;
    logic    r_in_start;
    logic    r_out_valid;
    logic    w_out_adv;

    bldcos_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    bldcos_step u_step (
        .i_cfg    (w_cfg),
        .i_state  (r_state),
        .i_start  (r_in_start),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign w_out_adv = !r_out_valid || !i_stall;
    assign o_stall   = r_in_valid && !w_out_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_start <= i_start_request;
        end
    end

    // sequence state advances only when the tick moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= PH_IDLE;
            r_state.period     <= RST_ALIGN_TCK;
            r_state.countdown  <= 8'd0;
            r_state.step_idx   <= 3'd0;
            r_state.duty       <= 10'd0;
            r_state.comm_state <= 3'd0;
            r_out_valid        <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_phase          = r_result.phase;
    assign o_drive_valid    = r_result.drive_valid;
    assign o_drive_pair     = r_result.drive_pair;
    assign o_comm_state     = r_result.comm_state;
    assign o_duty           = r_result.duty;
    assign o_handover       = r_result.handover;
    assign o_handover_value = r_result.handover_value;

    a_ho_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_handover |-> o_phase == PHC_HANDED && !o_drive_valid)
        else $error("handover reported outside the handed-over phase");

    a_no_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_drive_valid |-> o_drive_pair == 3'd0)
        else $error("bridge pair set without drive");

    a_idle_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_phase == PHC_IDLE || o_phase == PHC_HANDED) |-> o_duty == 10'd0)
        else $error("duty reported while not aligning or ramping");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |=> $stable(r_state))
        else $error("sequence state changed without a tick");

endmodule

// ===== rtl/bldcos_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register bank of the start sequencer.
// Depends on bldcos_pkg for register indexes, reset values and t_cfg.
module bldcos_cfg import bldcos_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [17:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.table_bits  <= RST_TABLE;
            r_cfg.align_ticks <= RST_ALIGN_TCK;
            r_cfg.align_duty  <= RST_ALIGN_DUTY;
            r_cfg.ramp_duty   <= RST_RAMP_DUTY;
            r_cfg.ramp_period <= RST_RAMP_PER;
            r_cfg.duty_step   <= RST_DUTY_STEP;
            r_cfg.duty_max    <= RST_DUTY_MAX;
            r_cfg.bridge_mode <= RST_RUN_MODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TABLE:      r_cfg.table_bits  <= i_cfg_data;
                CFG_ALIGN_TCK:  r_cfg.align_ticks <= i_cfg_data[7:0];
                CFG_ALIGN_DUTY: r_cfg.align_duty  <= i_cfg_data[9:0];
                CFG_RAMP_DUTY:  r_cfg.ramp_duty   <= i_cfg_data[9:0];
                CFG_RAMP_PER:   r_cfg.ramp_period <= i_cfg_data[7:0];
                CFG_DUTY_STEP:  r_cfg.duty_step   <= i_cfg_data[7:0];
                CFG_DUTY_MAX:   r_cfg.duty_max    <= i_cfg_data[9:0];
                CFG_RUN_MODE:   r_cfg.bridge_mode <= i_cfg_data[1:0];
                default:        r_cfg.bridge_mode <= r_cfg.bridge_mode;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/bldcos_step.sv =====
`timescale 1ns / 1ps
// Next-state and result logic for one control tick: align, ramp, handover
// and bridge pair selection. Pure combinational; depends on bldcos_pkg.
module bldcos_step import bldcos_pkg::*; (
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  logic    i_start,
    output t_state  o_state,
    output t_result o_result
);

    always_comb begin
        t_state      s;
        t_result     res;
        logic [10:0] sum;
        logic [2:0]  pair;

        s    = i_state;
        res  = '0;
        sum  = {1'b0, s.duty} + {3'b000, i_cfg.duty_step};
        pair = 3'd0;

        if (i_start && (s.phase == PH_IDLE || s.phase == PH_HANDED)) begin
            s.phase    = PH_ALIGN;
            s.period   = i_cfg.align_ticks;
            s.step_idx = 3'd0;
        end

        if (s.phase == PH_ALIGN) begin
            s.comm_state = ALIGN_STATE;
            s.duty       = i_cfg.align_duty;
            s.period     = s.period - 8'd1;
            if (s.period == 8'd0) begin
                s.period    = i_cfg.ramp_period;
                s.countdown = i_cfg.ramp_period;
                s.duty      = i_cfg.ramp_duty;
                s.phase     = PH_RAMP;
            end
        end

        if (s.phase == PH_RAMP) begin
            s.countdown = s.countdown - 8'd1;
            if (s.countdown == 8'd0) begin
                s.countdown  = s.period;
                s.comm_state = table_entry(i_cfg.table_bits, s.step_idx);
                s.step_idx   = s.step_idx + 3'd1;
                // full cycle: raise duty, shorten period; hand over at 1
                if (s.step_idx >= 3'(STEPS_PER_CYCLE)) begin
                    sum        = {1'b0, s.duty} + {3'b000, i_cfg.duty_step};
                    s.step_idx = 3'd0;
                    s.duty     = (sum >= {1'b0, i_cfg.duty_max}) ? i_cfg.duty_max
                                                                  : sum[9:0];
                    s.period    = s.period - 8'd1;
                    s.countdown = s.period;
                    if (s.period == 8'd1) begin
                        s.phase            = PH_HANDED;
                        res.handover       = 1'b1;
                        res.handover_value = s.duty;
                        s.period           = i_cfg.align_ticks;
                        s.countdown        = i_cfg.align_ticks;
                        s.step_idx         = 3'd0;
                    end
                end
            end
        end

        if (s.phase == PH_ALIGN || s.phase == PH_RAMP) begin
            res.duty = s.duty;
            if (s.comm_state != 3'd0 && s.comm_state != 3'd7) begin
                if (i_cfg.bridge_mode == MODE_FWD) begin
                    res.drive_valid = 1'b1;
                    pair            = pair_fwd(s.comm_state);
                end else if (i_cfg.bridge_mode == MODE_REV) begin
                    res.drive_valid = 1'b1;
                    pair            = pair_rev(s.comm_state);
                end
            end
        end

        res.phase      = phase_code(s.phase);
        res.drive_pair = pair;
        res.comm_state = s.comm_state;

        o_state  = s;
        o_result = res;
    end

endmodule
